@@ rtl/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

	// Hue sectors of the six-sector scheme, named by the channel that holds V
	// and the channel that moves within the sector.
	typedef enum logic [2:0] {
		SEC_RED_GREEN_UP   = 3'd0,
		SEC_GREEN_RED_DOWN = 3'd1,
		SEC_GREEN_BLUE_UP  = 3'd2,
		SEC_BLUE_GREEN_DOWN = 3'd3,
		SEC_BLUE_RED_UP    = 3'd4,
		SEC_RED_BLUE_DOWN  = 3'd5
	} sector_t;

	localparam logic [2:0] SectorCount = 3'd6;

	// Word leaving the front end: sector, fraction and effective saturation.
	typedef struct packed {
		logic        valid;
		sector_t     sec;
		logic [7:0]  frac;
		logic [7:0]  sat;
		logic [7:0]  val;
		logic        grey;
		logic        black;
	} front_t;

	// Word leaving the scaling pipe: p is final, q and t are one step short.
	typedef struct packed {
		logic        valid;
		sector_t     sec;
		logic [7:0]  val;
		logic [7:0]  p;
		logic [15:0] zq;
		logic [15:0] zt;
		logic        grey;
		logic        black;
	} scale_t;

	// Floor of y/255 for any 24-bit y whose quotient fits in 16 bits.
	// The shifted sum never overshoots and falls short by at most one, which
	// a single remainder compare repairs.
	function automatic logic [15:0] div255(input logic [23:0] y);
		logic [24:0] sum;
		logic [15:0] est;
		logic [23:0] rem;
		sum = {1'b0, y} + {9'b0, y[23:8]} + {17'b0, y[23:16]};
		est = sum[23:8];
		rem = y - ({est, 8'b0} - {8'b0, est});
		if (rem >= 24'd255) begin
			est = est + 16'd1;
		end
		return est;
	endfunction

endpackage

@@ rtl/hsv2rgb_front.sv @@
module hsv2rgb_front
	import hsv2rgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       curve_mode,
	input  logic [7:0] hue_in,
	input  logic [7:0] sat_in,
	input  logic [7:0] val_in,
	output front_t     front
);

	logic        v_s1;
	logic [15:0] dd_s1;
	logic [10:0] six_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  val_s1;
	logic        grey_s1;
	logic        black_s1;
	logic        curve_s1;

	logic        v_s2;
	sector_t     sec_s2;
	logic [7:0]  frac_s2;
	logic [7:0]  sat_s2;
	logic [7:0]  val_s2;
	logic        grey_s2;
	logic        black_s2;

	logic [7:0]  dsat;
	logic [15:0] div_dd;
	logic [15:0] div_six;
	logic [2:0]  sec_raw;
	logic [10:0] sec_base;
	logic [10:0] frac_w;
	logic [7:0]  sat_eff;
	sector_t     sec_wrapped;

	assign dsat = 8'd255 - sat_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		dd_s1    <= 16'(dsat) * 16'(dsat);
		six_s1   <= 11'(hue_in) * 11'd6;
		sat_s1   <= sat_in;
		val_s1   <= val_in;
		grey_s1  <= (sat_in == 8'd0);
		black_s1 <= (val_in == 8'd0);
		curve_s1 <= curve_mode && (sat_in >= 8'd2);
	end

	// The curve test uses raw saturation; the sector index reaches six only
	// at full hue, which folds back onto the first sector.
	always_comb begin
		div_dd   = div255(24'(dd_s1));
		div_six  = div255(24'(six_s1));
		sec_raw  = div_six[2:0];
		sec_base = {sec_raw, 8'b0} - 11'(sec_raw);
		frac_w   = six_s1 - sec_base;
		sat_eff  = curve_s1 ? (8'd255 - div_dd[7:0]) : sat_s1;
		if (sec_raw == SectorCount) begin
			sec_wrapped = SEC_RED_GREEN_UP;
		end else begin
			sec_wrapped = sector_t'(sec_raw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sec_s2   <= sec_wrapped;
		frac_s2  <= frac_w[7:0];
		sat_s2   <= sat_eff;
		val_s2   <= val_s1;
		grey_s2  <= grey_s1;
		black_s2 <= black_s1;
	end

	assign front = {v_s2, sec_s2, frac_s2, sat_s2, val_s2, grey_s2, black_s2};

endmodule

@@ rtl/hsv2rgb_scale.sv @@
module hsv2rgb_scale
	import hsv2rgb_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  front_t front,
	output scale_t scale
);

	logic        v_s3;
	sector_t     sec_s3;
	logic [7:0]  val_s3;
	logic [15:0] kq_s3;
	logic [15:0] kt_s3;
	logic [15:0] pp_s3;
	logic        grey_s3;
	logic        black_s3;

	logic        v_s4;
	sector_t     sec_s4;
	logic [7:0]  val_s4;
	logic [7:0]  p_s4;
	logic [23:0] yq_s4;
	logic [23:0] yt_s4;
	logic        grey_s4;
	logic        black_s4;

	logic        v_s5;
	sector_t     sec_s5;
	logic [7:0]  val_s5;
	logic [7:0]  p_s5;
	logic [15:0] zq_s5;
	logic [15:0] zt_s5;
	logic        grey_s5;
	logic        black_s5;

	logic [15:0] p_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s3 <= front.valid;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage three forms the saturation products of q, t and p.
	always_ff @(posedge clk) begin
		kq_s3    <= 16'(front.frac) * 16'(front.sat);
		kt_s3    <= 16'(8'd255 - front.frac) * 16'(front.sat);
		pp_s3    <= 16'(front.val) * 16'(8'd255 - front.sat);
		sec_s3   <= front.sec;
		val_s3   <= front.val;
		grey_s3  <= front.grey;
		black_s3 <= front.black;
	end

	assign p_div = div255(24'(pp_s3));

	// Stage four scales by value; p is already complete here.
	always_ff @(posedge clk) begin
		yq_s4    <= 24'(val_s3) * 24'(16'd65025 - kq_s3);
		yt_s4    <= 24'(val_s3) * 24'(16'd65025 - kt_s3);
		p_s4     <= p_div[7:0];
		sec_s4   <= sec_s3;
		val_s4   <= val_s3;
		grey_s4  <= grey_s3;
		black_s4 <= black_s3;
	end

	// Stage five takes the first of two divisions by 255.
	always_ff @(posedge clk) begin
		zq_s5    <= div255(yq_s4);
		zt_s5    <= div255(yt_s4);
		p_s5     <= p_s4;
		sec_s5   <= sec_s4;
		val_s5   <= val_s4;
		grey_s5  <= grey_s4;
		black_s5 <= black_s4;
	end

	assign scale = {v_s5, sec_s5, val_s5, p_s5, zq_s5, zt_s5, grey_s5, black_s5};

endmodule

@@ rtl/hsv2rgb_mix.sv @@
module hsv2rgb_mix
	import hsv2rgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  scale_t     scale,
	output logic       done,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);

	logic [15:0] q_div;
	logic [15:0] t_div;
	logic [7:0]  q;
	logic [7:0]  t;
	logic [7:0]  r_nxt;
	logic [7:0]  g_nxt;
	logic [7:0]  b_nxt;

	assign q_div = div255(24'(scale.zq));
	assign t_div = div255(24'(scale.zt));
	assign q     = q_div[7:0];
	assign t     = t_div[7:0];

	always_comb begin
		if (scale.grey) begin
			r_nxt = scale.val;
			g_nxt = scale.val;
			b_nxt = scale.val;
		end else if (scale.black) begin
			r_nxt = 8'd0;
			g_nxt = 8'd0;
			b_nxt = 8'd0;
		end else begin
			unique case (scale.sec)
				SEC_RED_GREEN_UP: begin
					r_nxt = scale.val; g_nxt = t; b_nxt = scale.p;
				end
				SEC_GREEN_RED_DOWN: begin
					r_nxt = q; g_nxt = scale.val; b_nxt = scale.p;
				end
				SEC_GREEN_BLUE_UP: begin
					r_nxt = scale.p; g_nxt = scale.val; b_nxt = t;
				end
				SEC_BLUE_GREEN_DOWN: begin
					r_nxt = scale.p; g_nxt = q; b_nxt = scale.val;
				end
				SEC_BLUE_RED_UP: begin
					r_nxt = t; g_nxt = scale.p; b_nxt = scale.val;
				end
				default: begin
					r_nxt = scale.val; g_nxt = scale.p; b_nxt = q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= scale.valid;
		end
	end

	always_ff @(posedge clk) begin
		red_out   <= r_nxt;
		green_out <= g_nxt;
		blue_out  <= b_nxt;
	end

endmodule

@@ rtl/hsv_to_rgb_converter.sv @@
// A word accepted with start comes out with done high once it has passed
// the six pipeline registers, one per stage.
// Throughput: one word per clock; busy is always low and the pipe never stalls.
// Reset (arst_n low, asynchronous) clears every valid bit and curve_mode.
// The result is shown for exactly one cycle and the receiver cannot stall it.
module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] hue_in,
	input  logic [7:0] sat_in,
	input  logic [7:0] val_in,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	output logic       done,
	output logic [7:0] red_out,
	output logic [7:0] green_out,
	output logic [7:0] blue_out
);

	// The only register, for the LED saturation curve. The user writes it only
	// while the pipe is empty (unenforced here), so items in flight never see it change.
	logic curve_q;

	front_t front;
	scale_t scale;

	// Every stage advances every cycle, so a new word can be taken at each
	// edge and nothing ever holds the input off.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			curve_q <= cfg_data;
		end
	end

	// Stages one and two: the saturation curve and the hue sector with its
	// fraction. Squares and the hue scaling are registered before the
	// divisions by 255, which are shift-add estimates with one correction.
	hsv2rgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start && !busy),
		.curve_mode (curve_q),
		.hue_in     (hue_in),
		.sat_in     (sat_in),
		.val_in     (val_in),
		.front      (front)
	);

	// Stages three to five: saturation products, scaling by value, and the
	// first division of q and t by 255. The divisor 65025 is taken as two
	// successive divisions by 255, which give the same floor.
	hsv2rgb_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.front  (front),
		.scale  (scale)
	);

	// Stage six: the second division, sector selection of the three
	// channels, and the grey and black special cases. Grey uses the raw
	// saturation and wins over black, which matches for zero value anyway.
	hsv2rgb_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.scale     (scale),
		.done      (done),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

`ifndef ASSERT_OFF
	// Every accepted word produces a result once it has passed through the pipe.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("accepted word did not produce a result after six cycles");

	// A result never appears without a matching word accepted before it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 6))
		else $error("result strobe without a matching accepted word");

	// Zero saturation yields a grey pixel.
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && sat_in == 8'd0, 6)) |->
		(red_out == green_out && green_out == blue_out))
		else $error("zero saturation did not give equal channels");
`endif

endmodule
